### design/rrts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and codes shared by the round-robin task scheduler modules.
// ----------------------------------------------------------------------------
package rrts_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  slot;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] rel_deadline;
    logic [15:0] io_point;
    logic [15:0] io_length;
  } in_item_t;

  typedef struct packed {
    logic [31:0] tick_time;
    logic [2:0]  event_res;
    logic [5:0]  task_slot;
    logic [31:0] finish_time;
    logic [31:0] turnaround;
    logic [31:0] waiting_time;
    logic [31:0] resp_time;
    logic        deadline_missed;
    logic        all_done;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_NEW, PH_READY, PH_RUNNING, PH_WAITING, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    EV_IDLE, EV_OVERHEAD, EV_RAN, EV_BLOCKED, EV_COMPLETED, EV_EXPIRED
  } ev_t;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] CFG_QUANTUM    = 2'd0;
  localparam logic [1:0] CFG_OVERHEAD   = 2'd1;
  localparam logic [1:0] CFG_TASK_COUNT = 2'd2;

  // Task definition, written by load items.
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [16:0] due_tick;
    logic [15:0] io_point;
    logic [15:0] io_length;
  } def_t;

  // Per-task run state, reinitialised by a sweep on start and cleared by one after reset.
  typedef struct packed {
    logic [15:0] remaining;
    logic [15:0] executed;
    logic [31:0] io_begin;
    logic        io_started;
    phase_t      phase;
    logic [31:0] first_dispatch;
  } run_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } ring_ctl_t;

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_SCAN_IO, ST_SCAN_ARR, ST_DISPATCH,
    ST_POP, ST_EXEC, ST_FIN, ST_EMIT
  } state_t;

endpackage
`default_nettype wire

### design/rrts_task_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_task_store
// Definition and run-state memories, one shared registered read port.
// ----------------------------------------------------------------------------
module rrts_task_store
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 64,
  parameter int IW = 6
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [IW-1:0] rd_addr,
  input  wire logic          def_we,
  input  wire logic [IW-1:0] def_addr,
  input  wire def_t          def_d,
  input  wire logic          run_we,
  input  wire logic [IW-1:0] run_addr,
  input  wire run_t          run_d,
  output def_t               def_q,
  output run_t               run_q
);

  def_t def_mem [MAX_TASKS];
  run_t run_mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (def_we) begin
      def_mem[def_addr] <= def_d;
    end
    if (rd_en) begin
      def_q <= def_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (run_we) begin
      run_mem[run_addr] <= run_d;
    end
    if (rd_en) begin
      run_q <= run_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### design/rrts_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_ring
// FIFO ring of ready slots; head entry read into a register on pop.
// ----------------------------------------------------------------------------
module rrts_ring
  import rrts_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int SW = 6,
  parameter int CW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ring_ctl_t     ctl,
  input  wire logic [SW-1:0] push_slot,
  output logic [SW-1:0]      head_slot,
  output logic [CW-1:0]      count
);

  localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SW-1:0] ring_mem [DEPTH];
  logic [RW-1:0] head;
  logic [RW-1:0] tail;
  logic          full;

  assign full = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (ctl.push && !full) begin
      ring_mem[tail] <= push_slot;
    end
    if (ctl.pop) begin
      head_slot <= ring_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      // drop a push into a full ring
      if (ctl.push && !full) begin
        tail  <= (tail == RW'(DEPTH - 1)) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end else if (ctl.pop && count != '0) begin
        head  <= (head == RW'(DEPTH - 1)) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) count <= CW'(DEPTH);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("ring count over depth");

  property p_pop_not_empty;
    @(posedge clk) disable iff (rst) ctl.pop |-> count != '0;
  endproperty
  a_pop_not_empty: assert property (p_pop_not_empty) else $error("pop from empty ring");

  property p_no_push_pop;
    @(posedge clk) disable iff (rst) !(ctl.push && ctl.pop);
  endproperty
  a_no_push_pop: assert property (p_no_push_pop) else $error("push and pop together");

endmodule
`default_nettype wire

### design/round_robin_task_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Tick-driven round-robin scheduler; task state held in synchronous memories.
// ----------------------------------------------------------------------------
// Start item: a sweep over the run-state memory.
// Tick item: for the slots in use, a scan for I/O completions, then one for arrivals,
//   through the single read port; then dispatch, execute and emit, the last of which
//   may be held by output stalls.
// Reset: synchronous; a clearing pass over the run-state memory follows, during which
//   no item is accepted.
module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 64,
  parameter int RING_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int RCW = $clog2(RING_DEPTH + 1);

  state_t state, state_next;

  logic [15:0] quantum;
  logic [15:0] dispatch_overhead;
  logic [6:0]  task_count;

  logic [8:0]    cnt;
  logic          p_valid;
  logic [IW-1:0] p_slot;
  logic          sweep_zero;
  logic [31:0]   sim_clock;
  logic [31:0]   t0;
  logic          running_valid;
  logic [IW-1:0] running_slot;
  logic [15:0]   slice_rem;
  logic [15:0]   overhead_left;
  logic [8:0]    finished;
  logic          dispatched;
  out_item_t     res;
  logic [31:0]   tat_r;
  logic [16:0]   sum_r;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          def_we;
  logic [IW-1:0] def_addr;
  def_t          def_d;
  logic          run_we;
  logic [IW-1:0] run_addr;
  run_t          run_d;
  def_t          def_q;
  run_t          run_q;
  ring_ctl_t     ring_ctl;
  logic [IW-1:0] push_slot;
  logic [IW-1:0] ring_q;
  logic [RCW-1:0] ring_count;

  logic [8:0]     n_use;
  logic [8:0]     limit;
  logic           scan_rd;
  logic           scan_end;
  logic [IW+5:0]  slot_w;
  logic           slot_ok;
  logic [IW+5:0]  rs_w;
  logic [31:0]    clk_inc;
  logic           io_done_hit;
  logic           arr_hit;

  // execute stage
  logic [15:0] sl_base;
  logic [15:0] rem_n;
  logic [15:0] exe_n;
  logic [15:0] slice_n;
  logic [31:0] fd;
  logic        io_hit;
  logic        done_hit;
  logic        exp_hit;
  logic [31:0] tat;
  logic [31:0] resp;
  logic        miss;
  logic [31:0] wt;
  logic        emit_fire;

  rrts_task_store #(.MAX_TASKS(MAX_TASKS), .IW(IW)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .def_we  (def_we),
    .def_addr(def_addr),
    .def_d   (def_d),
    .run_we  (run_we),
    .run_addr(run_addr),
    .run_d   (run_d),
    .def_q   (def_q),
    .run_q   (run_q)
  );

  rrts_ring #(.DEPTH(RING_DEPTH), .SW(IW), .CW(RCW)) u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ring_ctl),
    .push_slot(push_slot),
    .head_slot(ring_q),
    .count    (ring_count)
  );

  assign n_use = ({2'b0, task_count} > 9'(MAX_TASKS)) ? 9'(MAX_TASKS) : {2'b0, task_count};
  assign limit = (state == ST_SWEEP) ? 9'(MAX_TASKS) : n_use;
  assign scan_rd = (cnt < limit);
  assign scan_end = !scan_rd && !p_valid;
  assign slot_w = {{IW{1'b0}}, in_data.slot};
  assign slot_ok = (slot_w < (IW+6)'(MAX_TASKS));
  assign rs_w = {6'b0, running_slot};
  assign clk_inc = (sim_clock == 32'hFFFF_FFFF) ? sim_clock : sim_clock + 32'd1;
  assign in_stall = (state != ST_IDLE);
  assign emit_fire = (state == ST_EMIT) && (!out_valid || !out_stall);

  assign io_done_hit = (run_q.phase == PH_WAITING) && run_q.io_started &&
                       ({1'b0, sim_clock} == ({1'b0, run_q.io_begin} + {17'b0, def_q.io_length}));
  assign arr_hit = (run_q.phase == PH_NEW) && ({16'b0, def_q.arrival} == sim_clock);

  always_comb begin
    sl_base  = dispatched ? ((quantum == 16'd0) ? 16'd1 : quantum) : slice_rem;
    rem_n    = (run_q.remaining != 16'd0) ? run_q.remaining - 16'd1 : 16'd0;
    exe_n    = (run_q.executed != 16'hFFFF) ? run_q.executed + 16'd1 : run_q.executed;
    slice_n  = (sl_base != 16'd0) ? sl_base - 16'd1 : 16'd0;
    fd       = (dispatched && run_q.executed == 16'd0) ? sim_clock : run_q.first_dispatch;
    io_hit   = (def_q.io_point != 16'd0) && (def_q.io_point < def_q.burst) &&
               !run_q.io_started && (exe_n == def_q.io_point);
    done_hit = (rem_n == 16'd0);
    exp_hit  = (slice_n == 16'd0);
    tat      = (clk_inc >= {16'b0, def_q.arrival}) ? clk_inc - {16'b0, def_q.arrival} : 32'd0;
    resp     = (fd >= {16'b0, def_q.arrival}) ? fd - {16'b0, def_q.arrival} : 32'd0;
    miss     = (clk_inc > {15'b0, def_q.due_tick});
    wt       = (tat_r > {15'b0, sum_r}) ? tat_r - {15'b0, sum_r} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = cnt[IW-1:0];
    def_we     = 1'b0;
    def_addr   = slot_w[IW-1:0];
    def_d.arrival      = in_data.arrival;
    def_d.burst        = in_data.burst;
    def_d.due_tick     = {1'b0, in_data.arrival} + {1'b0, in_data.rel_deadline};
    def_d.io_point     = in_data.io_point;
    def_d.io_length    = in_data.io_length;
    run_we     = 1'b0;
    run_addr   = p_slot;
    run_d      = run_q;
    ring_ctl   = '0;
    push_slot  = p_slot;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.action)
            ACT_LOAD: def_we = slot_ok;
            ACT_START: begin
              ring_ctl.clear = 1'b1;
              state_next = ST_SWEEP;
            end
            ACT_TICK: state_next = ST_SCAN_IO;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        rd_en = scan_rd;
        if (p_valid) begin
          run_we = 1'b1;
          run_d.remaining      = sweep_zero ? 16'd0 : def_q.burst;
          run_d.executed       = 16'd0;
          run_d.io_begin       = 32'd0;
          run_d.io_started     = 1'b0;
          run_d.phase          = PH_NEW;
          run_d.first_dispatch = 32'd0;
        end
        if (scan_end) state_next = ST_IDLE;
      end
      ST_SCAN_IO: begin
        rd_en = scan_rd;
        if (p_valid && io_done_hit) begin
          run_we = 1'b1;
          run_d.phase = PH_READY;
          ring_ctl.push = 1'b1;
        end
        if (scan_end) state_next = ST_SCAN_ARR;
      end
      ST_SCAN_ARR: begin
        rd_en = scan_rd;
        if (p_valid && arr_hit) begin
          run_we = 1'b1;
          run_d.phase = PH_READY;
          ring_ctl.push = 1'b1;
        end
        if (scan_end) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (overhead_left != 16'd0) begin
          state_next = ST_EMIT;
        end else if (!running_valid && ring_count != '0) begin
          ring_ctl.pop = 1'b1;
          state_next = ST_POP;
        end else if (running_valid) begin
          rd_en = 1'b1;
          rd_addr = running_slot;
          state_next = ST_EXEC;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_POP: begin
        rd_en = 1'b1;
        rd_addr = ring_q;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        run_we = 1'b1;
        run_addr = running_slot;
        run_d.remaining      = rem_n;
        run_d.executed       = exe_n;
        run_d.io_begin       = io_hit ? clk_inc : run_q.io_begin;
        run_d.io_started     = run_q.io_started | io_hit;
        run_d.first_dispatch = fd;
        push_slot = running_slot;
        if (io_hit) begin
          run_d.phase = PH_WAITING;
          state_next = ST_EMIT;
        end else if (done_hit) begin
          run_d.phase = PH_DONE;
          state_next = ST_FIN;
        end else if (exp_hit) begin
          run_d.phase = PH_READY;
          ring_ctl.push = 1'b1;
          state_next = ST_EMIT;
        end else begin
          run_d.phase = PH_RUNNING;
          state_next = ST_EMIT;
        end
      end
      ST_FIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum           <= 16'd4;
      dispatch_overhead <= 16'd0;
      task_count        <= 7'd1;
      cnt               <= '0;
      p_valid           <= 1'b0;
      sweep_zero        <= 1'b1;
      sim_clock         <= '0;
      running_valid     <= 1'b0;
      running_slot      <= '0;
      slice_rem         <= '0;
      overhead_left     <= '0;
      finished          <= '0;
      dispatched        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUANTUM:    quantum <= cfg_data;
          CFG_OVERHEAD:   dispatch_overhead <= cfg_data;
          CFG_TASK_COUNT: task_count <= cfg_data[6:0];
          default: ;
        endcase
      end

      if (state == ST_SWEEP || state == ST_SCAN_IO || state == ST_SCAN_ARR) begin
        p_valid <= scan_rd;
        if (scan_rd) begin
          cnt    <= cnt + 9'd1;
          p_slot <= cnt[IW-1:0];
        end
        if (scan_end) cnt <= '0;
      end else begin
        p_valid <= 1'b0;
        cnt <= '0;
      end

      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid && in_data.action == ACT_START) begin
            sweep_zero    <= 1'b0;
            sim_clock     <= '0;
            running_valid <= 1'b0;
            running_slot  <= '0;
            slice_rem     <= '0;
            overhead_left <= '0;
            finished      <= '0;
          end
        end
        ST_DISPATCH: begin
          if (overhead_left != 16'd0) begin
            overhead_left <= overhead_left - 16'd1;
            sim_clock <= clk_inc;
          end else if (!running_valid && ring_count != '0) begin
            dispatched <= 1'b1;
          end else if (running_valid) begin
            dispatched <= 1'b0;
          end else begin
            sim_clock <= clk_inc;
          end
        end
        ST_POP: begin
          running_slot  <= ring_q;
          running_valid <= 1'b1;
        end
        ST_EXEC: begin
          sim_clock <= clk_inc;
          slice_rem <= slice_n;
          if (io_hit || done_hit || exp_hit) begin
            running_valid <= 1'b0;
            overhead_left <= dispatch_overhead;
          end
          if (!io_hit && done_hit) finished <= finished + 9'd1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      t0 <= sim_clock;
    end
    case (state)
      ST_DISPATCH: begin
        res <= {t0, ((overhead_left != 16'd0) ? EV_OVERHEAD : EV_IDLE), 136'd0};
      end
      ST_EXEC: begin
        res.task_slot <= rs_w[5:0];
        tat_r <= tat;
        sum_r <= {1'b0, def_q.burst} + {1'b0, def_q.io_length};
        if (io_hit) begin
          res.event_res <= EV_BLOCKED;
        end else if (done_hit) begin
          res.event_res       <= EV_COMPLETED;
          res.finish_time     <= clk_inc;
          res.turnaround      <= tat;
          res.resp_time       <= resp;
          res.deadline_missed <= miss;
        end else if (exp_hit) begin
          res.event_res <= EV_EXPIRED;
        end else begin
          res.event_res <= EV_RAN;
        end
      end
      ST_FIN: res.waiting_time <= wt;
      ST_EMIT: begin
        if (emit_fire) begin
          out_data <= {res[$bits(out_item_t)-1:1], (finished >= n_use)};
        end
      end
      default: ;
    endcase
  end

  property p_exec_entry;
    @(posedge clk) disable iff (rst)
      state == ST_EXEC |-> $past(state) == ST_DISPATCH || $past(state) == ST_POP;
  endproperty
  a_exec_entry: assert property (p_exec_entry) else $error("execute without fetch");

  property p_pop_needs_ready;
    @(posedge clk) disable iff (rst)
      state == ST_POP |-> $past(ring_count) != '0 && !$past(running_valid);
  endproperty
  a_pop_needs_ready: assert property (p_pop_needs_ready) else $error("pop without ready task");

  property p_done_releases;
    @(posedge clk) disable iff (rst)
      (state == ST_FIN) |-> !running_valid && res.event_res == EV_COMPLETED;
  endproperty
  a_done_releases: assert property (p_done_releases) else $error("completed task still running");

  property p_finished_bound;
    @(posedge clk) disable iff (rst) finished <= 9'(MAX_TASKS);
  endproperty
  a_finished_bound: assert property (p_finished_bound) else $error("finished count too high");

endmodule
`default_nettype wire
